>>> hdl/scancode_to_ascii_line_buffer_assert.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst_n in scope.
`ifndef SCANCODE_TO_ASCII_LINE_BUFFER_ASSERT_SVH
`define SCANCODE_TO_ASCII_LINE_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define SCTA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCTA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/scta_pkg.sv
`default_nettype none

package scta_pkg;

    // Sizing
    localparam int SCTA_LINE_CAPACITY = 128;
    localparam int SCTA_CHAR_W        = 7;
    localparam int SCTA_IDX_W         = 7;
    localparam int SCTA_COUNT_W       = 8;
    localparam int SCTA_ACTION_W      = 3;

    // Request kinds
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Scan codes (set 1)
    localparam logic [7:0] SC_CAPS      = 8'h3a;
    localparam logic [7:0] SC_LSHIFT_MK = 8'h2a;
    localparam logic [7:0] SC_LSHIFT_BR = 8'haa;
    localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BR = 8'hb6;
    localparam logic [7:0] SC_BKSP      = 8'h0e;
    localparam logic [7:0] SC_ENTER     = 8'h1c;

    // Line store actions
    localparam logic [SCTA_ACTION_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [SCTA_ACTION_W-1:0] ACT_APPENDED   = 3'd1;
    localparam logic [SCTA_ACTION_W-1:0] ACT_DROPPED    = 3'd2;
    localparam logic [SCTA_ACTION_W-1:0] ACT_ERASED     = 3'd3;
    localparam logic [SCTA_ACTION_W-1:0] ACT_ERASE_MT   = 3'd4;
    localparam logic [SCTA_ACTION_W-1:0] ACT_CLEARED    = 3'd5;

    typedef logic [SCTA_CHAR_W-1:0] char_t;

    typedef struct packed {
        logic                  req_type;
        logic [7:0]            scan_byte;
        logic [SCTA_IDX_W-1:0] read_index;
    } scta_in_t;

    typedef struct packed {
        logic                     key_valid;
        char_t                    key_char;
        logic [SCTA_ACTION_W-1:0] action;
        logic [SCTA_COUNT_W-1:0]  line_count;
        char_t                    read_char;
    } scta_out_t;

    // Unshifted key map
    function automatic char_t plain_char(input logic [6:0] code);
        char_t c;
        case (code)
            7'd1:  c = 7'h1b;  7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;  7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;  7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2d;
            7'd13: c = 7'h3d;  7'd14: c = 7'h7f;  7'd15: c = 7'h09;  7'd16: c = 7'h71;
            7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;
            7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6f;
            7'd25: c = 7'h70;  7'd26: c = 7'h5b;  7'd27: c = 7'h5d;  7'd28: c = 7'h0a;
            7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
            7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6a;  7'd37: c = 7'h6b;
            7'd38: c = 7'h6c;  7'd39: c = 7'h3b;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
            7'd43: c = 7'h5c;  7'd44: c = 7'h7a;  7'd45: c = 7'h78;  7'd46: c = 7'h63;
            7'd47: c = 7'h76;  7'd48: c = 7'h62;  7'd49: c = 7'h6e;  7'd50: c = 7'h6d;
            7'd51: c = 7'h2c;  7'd52: c = 7'h2e;  7'd53: c = 7'h2f;  7'd55: c = 7'h2a;
            7'd57: c = 7'h20;  7'd71: c = 7'h37;  7'd72: c = 7'h38;  7'd73: c = 7'h39;
            7'd74: c = 7'h2d;  7'd75: c = 7'h34;  7'd76: c = 7'h35;  7'd77: c = 7'h36;
            7'd78: c = 7'h2b;  7'd79: c = 7'h31;  7'd80: c = 7'h32;  7'd81: c = 7'h33;
            7'd82: c = 7'h30;  7'd83: c = 7'h2e;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted key map
    function automatic char_t shift_char(input logic [6:0] code);
        char_t c;
        case (code)
            7'd1:  c = 7'h1b;  7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;  7'd6:  c = 7'h25;  7'd7:  c = 7'h5e;  7'd8:  c = 7'h26;
            7'd9:  c = 7'h2a;  7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5f;
            7'd13: c = 7'h2b;  7'd14: c = 7'h7f;  7'd15: c = 7'h09;  7'd16: c = 7'h51;
            7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;
            7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4f;
            7'd25: c = 7'h50;  7'd26: c = 7'h7b;  7'd27: c = 7'h7d;  7'd28: c = 7'h0a;
            7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
            7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4a;  7'd37: c = 7'h4b;
            7'd38: c = 7'h4c;  7'd39: c = 7'h3a;  7'd40: c = 7'h22;  7'd41: c = 7'h7e;
            7'd43: c = 7'h7c;  7'd44: c = 7'h5a;  7'd45: c = 7'h58;  7'd46: c = 7'h43;
            7'd47: c = 7'h56;  7'd48: c = 7'h42;  7'd49: c = 7'h4e;  7'd50: c = 7'h4d;
            7'd51: c = 7'h3c;  7'd52: c = 7'h3e;  7'd53: c = 7'h3f;  7'd55: c = 7'h2a;
            7'd57: c = 7'h20;  7'd71: c = 7'h37;  7'd72: c = 7'h38;  7'd73: c = 7'h39;
            7'd74: c = 7'h2d;  7'd75: c = 7'h34;  7'd76: c = 7'h35;  7'd77: c = 7'h36;
            7'd78: c = 7'h2b;  7'd79: c = 7'h31;  7'd80: c = 7'h32;  7'd81: c = 7'h33;
            7'd82: c = 7'h30;  7'd83: c = 7'h2e;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Letters follow shift XOR caps lock, everything else follows shift
    function automatic char_t translate(input logic [6:0] code, input logic shift,
                                        input logic caps);
        char_t base;
        logic  use_shift;
        base = plain_char(code);
        if (base inside {[7'h61:7'h7a]})
            use_shift = shift ^ caps;
        else
            use_shift = shift;
        return use_shift ? shift_char(code) : base;
    endfunction

endpackage

`default_nettype wire

>>> hdl/scta_stream_if.sv
`default_nettype none

// Valid/ready channel; a transaction completes when both are high at a clock edge.
interface scta_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/scta_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read, old data on a same-address collision.
module scta_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/scta_result_q.sv
`default_nettype none

// Two-entry result queue in front of the output channel.
module scta_result_q
    import scta_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scta_out_t    push_data,
    output logic [1:0]   count,
    scta_stream_if.source deq
);

    scta_out_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop         = deq.valid && deq.ready;
    assign deq.valid   = (cnt_reg != 2'd0);
    assign deq.payload = slot_reg[rd_ptr_reg];
    assign count       = cnt_reg;

    // Pointer and occupancy update; caller guarantees room on push
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/scancode_to_ascii_line_buffer.sv
`default_nettype none

// Scan-code set 1 to ASCII translator with a line store. One request is accepted per
// clock cycle while there is room, and each gives exactly one result via the read
// stage and the result queue; the rate of one per cycle is set by the line store
// RAM, which takes one write and one read each cycle, with a same-cycle append to
// the entry being read forwarded around it. A two-entry result queue lets new requests
// enter while results wait at the output. The store needs no clearing after reset:
// only entries below the fill count are ever returned, and read_char is zero beyond it.
module scancode_to_ascii_line_buffer
    import scta_pkg::*;
#(
    parameter int LINE_CAPACITY = SCTA_LINE_CAPACITY
)
(
    input  logic          clk,
    input  logic          rst_n,
    scta_stream_if.sink   scan,
    scta_stream_if.source result
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int XW = (CW > SCTA_IDX_W) ? CW : SCTA_IDX_W;
    localparam int LW = (CW > SCTA_COUNT_W) ? CW : SCTA_COUNT_W;

    typedef struct packed {
        scta_out_t rsp;
        logic      hit;
        logic      fwd;
        char_t     fwd_char;
    } stage_t;

    // Keyboard state
    logic          shift_reg, shift_next;
    logic          caps_reg, caps_next;
    char_t         last_char_reg, last_char_next;
    logic [CW-1:0] fill_reg, fill_next;

    // Read stage
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;

    scta_in_t                 item;
    logic                     accept;
    logic                     is_make;
    logic                     is_break;
    logic                     key_valid;
    logic [SCTA_ACTION_W-1:0] action;
    logic                     wen;
    logic [XW-1:0]            idx_x;
    logic [LW-1:0]            fill_w;
    char_t                    ram_rdata;
    scta_out_t                push_data;
    logic [1:0]               q_count;
    logic [1:0]               total;

    assign item     = scan.payload;
    assign accept   = scan.valid && scan.ready;
    assign is_make  = (item.req_type == REQ_SCAN) && !item.scan_byte[7];
    assign is_break = (item.req_type == REQ_SCAN) && item.scan_byte[7];
    assign idx_x    = XW'(item.read_index);

    // Room for one more transaction counting the read stage and the queue
    assign total      = {1'b0, s1_valid_reg} + q_count;
    assign scan.ready = (total < 2'd2) || (result.valid && result.ready);

    // Flag, character and fill update for the accepted transaction
    always_comb
    begin
        shift_next     = shift_reg;
        caps_next      = caps_reg;
        last_char_next = last_char_reg;
        fill_next      = fill_reg;
        key_valid      = 1'b0;
        action         = ACT_NONE;
        wen            = 1'b0;
        if (accept && is_break)
        begin
            if (item.scan_byte == SC_LSHIFT_BR || item.scan_byte == SC_RSHIFT_BR)
            begin
                shift_next = 1'b0;
            end
        end
        if (accept && is_make)
        begin
            key_valid = 1'b1;
            if (item.scan_byte == SC_LSHIFT_MK || item.scan_byte == SC_RSHIFT_MK)
            begin
                shift_next = 1'b1;
            end
            if (item.scan_byte == SC_CAPS)
            begin
                caps_next = ~caps_reg;
            end
            last_char_next = translate(item.scan_byte[6:0], shift_next, caps_next);
            if (item.scan_byte == SC_ENTER)
            begin
                fill_next = '0;
                action    = ACT_CLEARED;
            end
            else if (item.scan_byte == SC_BKSP)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - CW'(1);
                    action    = ACT_ERASED;
                end
                else
                begin
                    action = ACT_ERASE_MT;
                end
            end
            else if (fill_reg >= CW'(LINE_CAPACITY))
            begin
                action = ACT_DROPPED;
            end
            else
            begin
                wen       = 1'b1;
                fill_next = fill_reg + CW'(1);
                action    = ACT_APPENDED;
            end
        end
    end

    assign fill_w = LW'(fill_next);

    // Fields for the read stage; an append to the entry being read is forwarded
    always_comb
    begin
        s1_next.rsp.key_valid  = key_valid;
        s1_next.rsp.key_char   = last_char_next;
        s1_next.rsp.action     = action;
        s1_next.rsp.line_count = fill_w[SCTA_COUNT_W-1:0];
        s1_next.rsp.read_char  = '0;
        s1_next.hit            = (idx_x < XW'(fill_next));
        s1_next.fwd            = wen && (idx_x == XW'(fill_reg));
        s1_next.fwd_char       = last_char_next;
    end

    scta_ram #(
        .WIDTH (SCTA_CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .clk   (clk),
        .we    (wen),
        .waddr (fill_reg[AW-1:0]),
        .wdata (last_char_next),
        .re    (accept),
        .raddr (idx_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            last_char_reg <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            last_char_reg <= last_char_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // Merge the store read into the result
    always_comb
    begin
        push_data = s1_reg.rsp;
        if (!s1_reg.hit)
        begin
            push_data.read_char = '0;
        end
        else if (s1_reg.fwd)
        begin
            push_data.read_char = s1_reg.fwd_char;
        end
        else
        begin
            push_data.read_char = ram_rdata;
        end
    end

    scta_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (push_data),
        .count     (q_count),
        .deq       (result)
    );

endmodule

`default_nettype wire

>>> hdl/scta_checker.sv
`default_nettype none

`include "scancode_to_ascii_line_buffer_assert.svh"

// Port-level checks on the translator.
module scta_checker
    import scta_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input scta_out_t out_payload
);

    logic                    in_fire;
    logic                    out_fire;
    logic [2:0]              pend_reg;
    logic [SCTA_COUNT_W-1:0] prev_count_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Transactions in flight and the count of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            prev_count_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'b0, in_fire} - {2'b0, out_fire};
            if (out_fire)
            begin
                prev_count_reg <= out_payload.line_count;
            end
        end
    end

    `SCTA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_payload), "result dropped or changed while stalled")

    `SCTA_ASSERT_IMP(a_no_extra, out_valid, pend_reg != 3'd0,
        "result without an accepted request")

    `SCTA_ASSERT_IMP(a_append_cnt, out_fire && out_payload.action == ACT_APPENDED,
        out_payload.line_count == prev_count_reg + 8'd1, "append did not grow the count")

    `SCTA_ASSERT_IMP(a_erase_cnt, out_fire && out_payload.action == ACT_ERASED,
        out_payload.line_count == prev_count_reg - 8'd1, "erase did not shrink the count")

endmodule

bind scancode_to_ascii_line_buffer scta_checker u_scta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (scan.valid),
    .in_ready    (scan.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);

`default_nettype wire

>>> test/scta_line_checker.sv
// Watches both channels, predicts every result from its own model of the
// translator and line store, and compares each result transaction in order.
module scta_line_checker
    import scta_pkg::*;
#(
    parameter int CAPACITY = SCTA_LINE_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      scan_valid,
    input  logic      scan_ready,
    input  scta_in_t  scan_payload,
    input  logic      result_valid,
    input  logic      result_ready,
    input  scta_out_t result_payload,
    output int        fail_count,
    output int        pending_count,
    output int        checked_count,
    output int        drop_count,
    output int        peak_fill
);

    localparam char_t ASCII_ESC     = 7'h1b;
    localparam char_t ASCII_TAB     = 7'h09;
    localparam char_t ASCII_LF      = 7'h0a;
    localparam char_t ASCII_DEL     = 7'h7f;
    localparam char_t ASCII_GRAVE   = 7'h60;
    localparam char_t ASCII_TILDE   = 7'h7e;
    localparam char_t ASCII_LOWER_A = 7'h61;
    localparam char_t ASCII_LOWER_Z = 7'h7a;

    // Key maps, plain and shifted
    char_t plain_map [128];
    char_t shift_map [128];

    // Predicted block state
    logic  shift_held;
    logic  caps_on;
    char_t last_char;
    int    fill;
    char_t line_copy [CAPACITY];

    scta_out_t expected_q [$];
    scta_out_t want;
    int        fails   = 0;
    int        waiting = 0;
    int        checked = 0;
    int        drops   = 0;
    int        peak    = 0;

    assign fail_count    = fails;
    assign pending_count = waiting;
    assign checked_count = checked;
    assign drop_count    = drops;
    assign peak_fill     = peak;

    // A run of consecutive codes with their plain and shifted characters
    task automatic load_keys(input int first, input string lo, input string hi);
        byte b;
        for (int i = 0; i < lo.len(); i++)
        begin
            b = lo[i];
            plain_map[first + i] = b[6:0];
            b = hi[i];
            shift_map[first + i] = b[6:0];
        end
    endtask

    task automatic load_same(input int code, input char_t ch);
        plain_map[code] = ch;
        shift_map[code] = ch;
    endtask

    initial
    begin
        foreach (plain_map[i])
        begin
            plain_map[i] = '0;
            shift_map[i] = '0;
        end
        load_same(1, ASCII_ESC);
        load_keys(2, "1234567890-=", "!@#$%^&*()_+");
        load_same(14, ASCII_DEL);
        load_same(15, ASCII_TAB);
        load_keys(16, "qwertyuiop[]", "QWERTYUIOP{}");
        load_same(28, ASCII_LF);
        load_keys(30, "asdfghjkl;'", "ASDFGHJKL:\"");
        plain_map[41] = ASCII_GRAVE;
        shift_map[41] = ASCII_TILDE;
        load_keys(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
        load_keys(55, "*", "*");
        load_keys(57, " ", " ");
        load_keys(71, "789-456+1230.", "789-456+1230.");
    end

    // Advance the predicted state by one request and return its result
    function automatic scta_out_t apply_request(input scta_in_t req);
        scta_out_t  r;
        logic [6:0] code;
        char_t      base;
        logic       use_upper;
        r = '0;
        code = req.scan_byte[6:0];
        if (req.req_type == REQ_SCAN)
        begin
            if (req.scan_byte[7])
            begin
                if (req.scan_byte == SC_LSHIFT_BR || req.scan_byte == SC_RSHIFT_BR)
                    shift_held = 1'b0;
            end
            else
            begin
                r.key_valid = 1'b1;
                if (req.scan_byte == SC_LSHIFT_MK || req.scan_byte == SC_RSHIFT_MK)
                    shift_held = 1'b1;
                if (req.scan_byte == SC_CAPS)
                    caps_on = ~caps_on;
                base = plain_map[code];
                if (base >= ASCII_LOWER_A && base <= ASCII_LOWER_Z)
                    use_upper = shift_held ^ caps_on;
                else
                    use_upper = shift_held;
                last_char = use_upper ? shift_map[code] : base;
                if (req.scan_byte == SC_ENTER)
                begin
                    fill = 0;
                    r.action = ACT_CLEARED;
                end
                else if (req.scan_byte == SC_BKSP)
                begin
                    if (fill > 0)
                    begin
                        fill--;
                        r.action = ACT_ERASED;
                    end
                    else
                        r.action = ACT_ERASE_MT;
                end
                else if (fill >= CAPACITY)
                begin
                    r.action = ACT_DROPPED;
                    drops++;
                end
                else
                begin
                    line_copy[fill] = last_char;
                    fill++;
                    r.action = ACT_APPENDED;
                end
            end
        end
        if (fill > peak)
            peak = fill;
        r.key_char   = last_char;
        r.line_count = 8'(fill);
        r.read_char  = (int'(req.read_index) < fill) ? line_copy[req.read_index] : '0;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held = 1'b0;
            caps_on    = 1'b0;
            last_char  = '0;
            fill       = 0;
            foreach (line_copy[i])
                line_copy[i] = '0;
            expected_q.delete();
            waiting = 0;
        end
        else
        begin
            // Result transaction: check against the oldest prediction
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with nothing expected, expected none, got %p",
                             $time, result_payload);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("key_valid", 8'(want.key_valid), 8'(result_payload.key_valid));
                    compare_field("key_char", 8'(want.key_char), 8'(result_payload.key_char));
                    compare_field("action", 8'(want.action), 8'(result_payload.action));
                    compare_field("line_count", want.line_count, result_payload.line_count);
                    compare_field("read_char", 8'(want.read_char), 8'(result_payload.read_char));
                    checked++;
                end
            end
            // Request transaction: predict its result
            if (scan_valid && scan_ready)
                expected_q.push_back(apply_request(scan_payload));
            waiting = expected_q.size();
        end
    end

endmodule

>>> test/tb_scancode_to_ascii_line_buffer.sv
// Drives keystroke sequences, reads and noise into the line buffer under
// several idle mixes; the checker beside the block does all the comparing.
module tb_scancode_to_ascii_line_buffer;
    import scta_pkg::*;

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam int         HOLD_CYCLES = 64;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 8;

    logic clk;
    logic rst_n;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int holds_wanted = 0;
    int holds_done   = 0;
    int sent_count   = 0;
    int quiet_cycles = 0;

    int fail_count;
    int pending_count;
    int checked_count;
    int drop_count;
    int peak_fill;

    scta_stream_if #(.payload_t(scta_in_t))  scan_ch ();
    scta_stream_if #(.payload_t(scta_out_t)) result_ch ();

    scancode_to_ascii_line_buffer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_ch),
        .result (result_ch)
    );

    scta_line_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan_valid     (scan_ch.valid),
        .scan_ready     (scan_ch.ready),
        .scan_payload   (scan_ch.payload),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .result_payload (result_ch.payload),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .drop_count     (drop_count),
        .peak_fill      (peak_fill)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Reset once at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (holds_done != holds_wanted)
            begin
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any transaction ends the run
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((scan_ch.valid && scan_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input scta_in_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            scan_ch.valid <= 1'b0;
            @(posedge clk);
        end
        scan_ch.valid   <= 1'b1;
        scan_ch.payload <= item;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Lines are mostly short, so favor low indexes half the time
    function automatic logic [6:0] pick_index();
        return $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(15));
    endfunction

    // A make code that neither ends nor edits the line
    function automatic logic [7:0] pick_key();
        logic [7:0] code;
        if ($urandom_range(99) < 85)
            code = 8'($urandom_range(1, 83));
        else
            code = 8'($urandom_range(84, 127));
        if (code == SC_ENTER || code == SC_BKSP)
            code = 8'($urandom_range(16, 25));
        return code;
    endfunction

    task automatic send_scan(input logic [7:0] code);
        scta_in_t item;
        item.req_type   = REQ_SCAN;
        item.scan_byte  = code;
        item.read_index = pick_index();
        send_item(item);
    endtask

    task automatic send_read(input logic [6:0] idx);
        scta_in_t item;
        item.req_type   = REQ_READ;
        item.scan_byte  = 8'($urandom_range(255));
        item.read_index = idx;
        send_item(item);
    endtask

    task automatic send_noise();
        scta_in_t item;
        item.req_type   = 1'($urandom_range(1));
        item.scan_byte  = 8'($urandom_range(255));
        item.read_index = 7'($urandom_range(127));
        send_item(item);
    endtask

    // One typed line: keys, shifted groups, caps, erases, reads, noise, then mostly enter
    task automatic send_line(input int len);
        logic [7:0] code;
        logic       left;
        int         roll;
        for (int k = 0; k < len; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                code = pick_key();
                send_scan(code);
                if ($urandom_range(99) < 30)
                    send_scan(code | BREAK_BIT);
            end
            else if (roll < 65)
            begin
                left = 1'($urandom_range(1));
                send_scan(left ? SC_LSHIFT_MK : SC_RSHIFT_MK);
                repeat ($urandom_range(1, 3))
                    send_scan(pick_key());
                send_scan(left ? SC_LSHIFT_BR : SC_RSHIFT_BR);
            end
            else if (roll < 70)
                send_scan(SC_CAPS);
            else if (roll < 80)
                send_scan(SC_BKSP);
            else if (roll < 92)
                send_read(pick_index());
            else
                send_noise();
        end
        if ($urandom_range(99) < 90)
            send_scan(SC_ENTER);
    endtask

    // Fill the store to the brim, overflow it, erase one, refill, clear
    task automatic send_full_line();
        repeat (SCTA_LINE_CAPACITY + 3)
            send_scan(pick_key());
        send_read(7'd127);
        send_read(7'd0);
        send_scan(SC_BKSP);
        send_scan(pick_key());
        send_scan(pick_key());
        send_read(7'd127);
        send_scan(SC_ENTER);
    endtask

    // Stimulus
    initial
    begin
        scan_ch.valid   = 1'b0;
        scan_ch.payload = '0;
        wait (rst_n);
        @(posedge clk);

        // Directed: empty store, caps and shift rules, breaks, extremes
        send_read(7'd0);
        send_scan(SC_BKSP);
        send_scan(8'h1e);
        send_scan(SC_CAPS);
        send_scan(8'h1e);
        send_scan(SC_LSHIFT_MK);
        send_scan(8'h1e);
        send_scan(8'h02);
        send_scan(8'h9e);
        send_scan(8'h10);
        send_scan(SC_LSHIFT_BR);
        send_scan(8'h02);
        send_scan(SC_RSHIFT_MK);
        send_scan(8'h1a);
        send_scan(SC_RSHIFT_BR);
        send_scan(SC_CAPS);
        send_scan(8'h7f);
        send_scan(8'h00);
        send_scan(8'hff);
        send_scan(SC_BKSP);
        send_read(7'd3);
        send_read(7'd127);
        send_scan(SC_ENTER);
        send_read(7'd0);

        // Random lines across four idle mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            if (phase == 0 || phase == 2)
                holds_wanted++;
            if (phase == 0 || phase == 3)
                send_full_line();
            while (sent_count < 25 + 130 * (phase + 1))
                send_line($urandom_range(0, 14));
        end
        scan_ch.valid <= 1'b0;

        // Let the checker log the last request before waiting on the drain
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d transactions over four idle mixes with long output hold-offs;",
                 checked_count);
        $display("line filled to %0d, %0d keys dropped on a full line", peak_fill, drop_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/scta_pkg.sv
hdl/scta_stream_if.sv
hdl/scta_ram.sv
hdl/scta_result_q.sv
hdl/scancode_to_ascii_line_buffer.sv
hdl/scta_checker.sv
test/scta_line_checker.sv
test/tb_scancode_to_ascii_line_buffer.sv
